// ===== rtl/core/iiee_pkg.sv =====
// shared types and constants of the infix integer expression evaluator
package iiee_pkg;

    localparam int DATA_WIDTH = 32;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    // operator waiting for the number being built
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_MUL   = 2'd1,
        OP_DIV   = 2'd2
    } t_op;

    // request to the multiply / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_mdu_req;

    // status from the multiply / divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_rsp;

endpackage

// ===== rtl/core/infix_integer_expression_evaluator.sv =====
// top level of the infix integer expression evaluator
//
// input channel: i_valid / o_ready carry one ascii character per item on i_char_code.
// digits build the current number, spaces are skipped, + - * / close an operand and
// '=' closes the expression. * and / bind tighter than + and -.
// output channel: o_valid / i_ready carry one result item per '=', o_value (32-bit
// two's complement, wraps at DATA_WIDTH and is sign-extended or cut to 32 bits) and
// o_status (0 ok, 1 divide by zero, 2 invalid character; first error is kept).
// per item: a digit, a space or an invalid character is taken in the idle state; an
// operator or '=' passes through the fold and post states, and also through the wait
// state of the bit-per-cycle multiply / divide unit when a * or / is pending (a / by
// zero skips it); o_ready stays low meanwhile. '=' then goes on to the emit state to
// load the output register, and waits there while a previous result is still held.
// the output register decouples the sides: a waiting result does not stop the input
// from taking further characters, only the next '=' waits for the register to empty.
// reset (synchronous, active low) clears the sum, term, number, operator, sign and
// error, and empties the output register.
module infix_integer_expression_evaluator import iiee_pkg::*; #(
    parameter int DATA_WIDTH_P = DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status
);

    localparam int W = DATA_WIDTH_P;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FOLD = 5'b00010,
        S_WAIT = 5'b00100,
        S_POST = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // operator character that closed the current operand
    typedef enum logic [2:0] {
        K_MUL = 3'd0,
        K_DIV = 3'd1,
        K_ADD = 3'd2,
        K_SUB = 3'd3,
        K_EQ  = 3'd4
    } t_kind;

    t_state       r_state, n_state;
    t_kind        r_kind, n_kind;
    t_op          r_op, n_op;
    logic [W-1:0] r_sum, n_sum;
    logic [W-1:0] r_prod, n_prod;
    logic [W-1:0] r_cur, n_cur;
    logic         r_neg, n_neg;
    logic [1:0]   r_err, n_err;
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_ovalue, n_ovalue;
    logic [1:0]   r_ostatus, n_ostatus;

    t_mdu_req     mdu_req;
    t_mdu_rsp     mdu_rsp;
    logic [W-1:0] mdu_result;

    logic         accept;
    logic         is_digit;
    logic [W-1:0] digit_val;
    logic [W-1:0] sum_fold;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign is_digit  = (i_char_code >= CH_0) && (i_char_code <= CH_9);
    assign digit_val = W'(i_char_code[3:0]);
    // finished term folded into the running sum
    assign sum_fold  = r_neg ? (r_sum - r_prod) : (r_sum + r_prod);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_op      = r_op;
        n_sum     = r_sum;
        n_prod    = r_prod;
        n_cur     = r_cur;
        n_neg     = r_neg;
        n_err     = r_err;
        n_ovalid  = r_ovalid && !i_ready;
        n_ovalue  = r_ovalue;
        n_ostatus = r_ostatus;
        mdu_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_digit) begin
                        // number times ten plus the new digit, wrapping
                        n_cur = (r_cur << 3) + (r_cur << 1) + digit_val;
                    end else if (i_char_code == CH_SPACE) begin
                        n_cur = r_cur;
                    end else if (i_char_code == CH_MUL) begin
                        n_kind  = K_MUL;
                        n_state = S_FOLD;
                    end else if (i_char_code == CH_DIV) begin
                        n_kind  = K_DIV;
                        n_state = S_FOLD;
                    end else if (i_char_code == CH_ADD) begin
                        n_kind  = K_ADD;
                        n_state = S_FOLD;
                    end else if (i_char_code == CH_SUB) begin
                        n_kind  = K_SUB;
                        n_state = S_FOLD;
                    end else if (i_char_code == CH_EQ) begin
                        n_kind  = K_EQ;
                        n_state = S_FOLD;
                    end else if (r_err == ST_OK) begin
                        n_err = ST_BADCHAR;
                    end
                end
            end
            S_FOLD: begin
                // apply the pending operator to the number just closed
                case (r_op)
                    OP_MUL: begin
                        mdu_req.start  = 1'b1;
                        mdu_req.is_div = 1'b0;
                        n_state        = S_WAIT;
                    end
                    OP_DIV: begin
                        if (r_cur == '0) begin
                            // division skipped, term keeps its value
                            if (r_err == ST_OK) begin
                                n_err = ST_DIV0;
                            end
                            n_state = S_POST;
                        end else begin
                            mdu_req.start  = 1'b1;
                            mdu_req.is_div = 1'b1;
                            n_state        = S_WAIT;
                        end
                    end
                    default: begin
                        n_prod  = r_cur;
                        n_state = S_POST;
                    end
                endcase
            end
            S_WAIT: begin
                if (mdu_rsp.done) begin
                    n_prod  = mdu_result;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_cur   = '0;
                n_state = S_IDLE;
                case (r_kind)
                    K_MUL: n_op = OP_MUL;
                    K_DIV: n_op = OP_DIV;
                    K_ADD, K_SUB: begin
                        n_sum = sum_fold;
                        n_neg = (r_kind == K_SUB);
                        n_op  = OP_START;
                    end
                    K_EQ: begin
                        n_sum   = sum_fold;
                        n_state = S_EMIT;
                    end
                    default: n_op = OP_START;
                endcase
            end
            S_EMIT: begin
                // load the result once the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ovalue  = (r_err == ST_OK) ? 32'($signed(r_sum)) : 32'd0;
                    n_ostatus = r_err;
                    n_sum     = '0;
                    n_prod    = '0;
                    n_cur     = '0;
                    n_op      = OP_START;
                    n_neg     = 1'b0;
                    n_err     = ST_OK;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    iiee_mdu #(
        .W (W)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mdu_req),
        .i_a      (r_prod),
        .i_b      (r_cur),
        .o_rsp    (mdu_rsp),
        .o_result (mdu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_ADD;
            r_op     <= OP_START;
            r_sum    <= '0;
            r_prod   <= '0;
            r_cur    <= '0;
            r_neg    <= 1'b0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_op     <= n_op;
            r_sum    <= n_sum;
            r_prod   <= n_prod;
            r_cur    <= n_cur;
            r_neg    <= n_neg;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
    end

    assign o_valid  = r_ovalid;
    assign o_value  = $signed(r_ovalue);
    assign o_status = r_ostatus;

    // the arithmetic unit only works while the controller waits on it
    a_mdu_busy_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_rsp.busy |-> (r_state == S_WAIT))
        else $error("arithmetic unit busy outside wait state");

    // a multiply or divide is only started when an operand is closed
    a_mdu_start_in_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_req.start |-> (r_state == S_FOLD) && (r_op == OP_MUL || r_op == OP_DIV))
        else $error("arithmetic unit started without a pending product");

    // loading a result clears the expression state
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (!r_ovalid || i_ready)
        |=> o_valid && (r_sum == '0) && (r_err == ST_OK) && (r_state == S_IDLE))
        else $error("expression state not cleared after result");

    // an error result always carries value zero
    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_value == 32'sd0))
        else $error("error result with non-zero value");

endmodule

// ===== rtl/core/iiee_mdu.sv =====
// iterative multiply / signed divide unit, one multiplier or quotient bit per cycle
module iiee_mdu import iiee_pkg::*; #(
    parameter int W = DATA_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mdu_req     i_req,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_mdu_rsp     o_rsp,
    output logic [W-1:0] o_result
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_div, n_div;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;
    logic [W-1:0]  r_acc, n_acc;

    logic [W-1:0]  a_abs, b_abs, rem_sh, q_neg;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        a_abs  = i_a[W-1] ? ({W{1'b0}} - i_a) : i_a;
        b_abs  = i_b[W-1] ? ({W{1'b0}} - i_b) : i_b;
        // remainder shifted left with the next dividend bit
        rem_sh = {r_acc[W-2:0], r_y[W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_div  = i_req.is_div;
            n_cnt  = CW'(W);
            n_acc  = '0;
            if (i_req.is_div) begin
                n_x   = b_abs;
                n_y   = a_abs;
                n_neg = i_a[W-1] ^ i_b[W-1];
            end else begin
                n_x   = i_a;
                n_y   = i_b;
                n_neg = 1'b0;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            if (r_div) begin
                if (rem_sh >= r_x) begin
                    n_acc = rem_sh - r_x;
                    n_y   = {r_y[W-2:0], 1'b1};
                end else begin
                    n_acc = rem_sh;
                    n_y   = {r_y[W-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[W-2:0], 1'b0};
                n_y = {1'b0, r_y[W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign q_neg       = {W{1'b0}} - r_y;
    assign o_result    = r_div ? (r_neg ? q_neg : r_y) : r_acc;
    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;

endmodule

// ===== dv/iiee_result_checker.sv =====
// result checker of the infix integer expression evaluator: tracks both channels and compares
`timescale 1ns / 1ps

module iiee_result_checker import iiee_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_in_char,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_out_value,
    input  logic [1:0]         i_out_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int DEC_BASE = 10;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_result;

    // shadow copy of the evaluator state
    t_word      sum_acc;
    t_word      term_acc;
    t_word      num_acc;
    t_op        op_wait;
    logic       term_sub;
    logic [1:0] err_kept;

    t_result results_due[$];
    int      fails   = 0;
    int      checked = 0;

    function automatic void clear_state();
        sum_acc  = '0;
        term_acc = '0;
        num_acc  = '0;
        op_wait  = OP_START;
        term_sub = 1'b0;
        err_kept = ST_OK;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        if (err_kept == ST_OK) begin
            err_kept = code;
        end
    endfunction

    // apply the waiting operator to the number just finished
    function automatic void close_operand();
        t_word mag_a;
        t_word mag_b;
        t_word quot;
        case (op_wait)
            OP_MUL: begin
                term_acc = term_acc * num_acc;
            end
            OP_DIV: begin
                if (num_acc == '0) begin
                    flag_error(ST_DIV0);
                end else begin
                    mag_a = term_acc[DATA_WIDTH-1] ? -term_acc : term_acc;
                    mag_b = num_acc[DATA_WIDTH-1] ? -num_acc : num_acc;
                    quot  = mag_a / mag_b;
                    if (term_acc[DATA_WIDTH-1] != num_acc[DATA_WIDTH-1]) begin
                        quot = -quot;
                    end
                    term_acc = quot;
                end
            end
            default: begin
                term_acc = num_acc;
            end
        endcase
        num_acc = '0;
    endfunction

    function automatic void close_term();
        sum_acc = term_sub ? sum_acc - term_acc : sum_acc + term_acc;
    endfunction

    function automatic void step_char(logic [7:0] c);
        t_result res;
        if (c >= CH_0 && c <= CH_9) begin
            num_acc = num_acc * t_word'(DEC_BASE) + t_word'(c - CH_0);
        end else begin
            case (c)
                CH_SPACE: begin
                end
                CH_MUL, CH_DIV: begin
                    close_operand();
                    op_wait = (c == CH_MUL) ? OP_MUL : OP_DIV;
                end
                CH_ADD, CH_SUB: begin
                    close_operand();
                    close_term();
                    term_sub = (c == CH_SUB);
                    op_wait  = OP_START;
                end
                CH_EQ: begin
                    close_operand();
                    close_term();
                    res.value  = (err_kept == ST_OK) ? 32'(signed'(sum_acc)) : '0;
                    res.status = err_kept;
                    results_due.push_back(res);
                    clear_state();
                end
                default: begin
                    flag_error(ST_BADCHAR);
                end
            endcase
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            results_due.delete();
        end else begin
            // results first: one taken at this edge belongs to an earlier '='
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, value %0d status %0d",
                             $time, i_out_value, i_out_status);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    checked++;
                    if (want.value !== i_out_value) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, want.value, i_out_value);
                        fails++;
                    end
                    if (want.status !== i_out_status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_out_status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_char(i_in_char);
            end
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
        o_checked    <= checked;
    end

endmodule

// ===== dv/infix_integer_expression_evaluator_tb.sv =====
// testbench top of the infix integer expression evaluator: stimulus and verdict
`timescale 1ns / 1ps

module infix_integer_expression_evaluator_tb import iiee_pkg::*; ();

    localparam int CHAR_TARGET = 1950;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_char_code;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    int fail_count;
    int results_due;
    int results_checked;

    // idling policy, switched off for a long stretch in the random part
    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;

    // characters of the expression about to be sent
    logic [7:0] char_q[$];
    int         chars_sent = 0;
    int         expr_idx   = 0;

    infix_integer_expression_evaluator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    iiee_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_char    (i_char_code),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_value  (o_value),
        .i_out_status (o_status),
        .o_fail_count (fail_count),
        .o_pending    (results_due),
        .o_checked    (results_checked)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // receiver side: drops ready with a chance of 31 in a hundred while stalling is on
    always @(posedge i_clk) begin
        i_ready <= !stall_on || ($urandom_range(99) >= 31);
    end

    // push one character, now and then followed by a space that must be ignored
    function automatic void put_char(logic [7:0] b);
        char_q.push_back(b);
        if ($urandom_range(99) < 8) begin
            char_q.push_back(CH_SPACE);
        end
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            char_q.push_back(s[i]);
        end
    endfunction

    // mostly short numbers, a few long enough to wrap past 32 bits
    function automatic void put_number();
        int ndig;
        ndig = ($urandom_range(99) < 10) ? $urandom_range(12, 4) : $urandom_range(3, 1);
        for (int i = 0; i < ndig; i++) begin
            put_char(CH_0 + 8'($urandom_range(9)));
        end
    endfunction

    // a character the evaluator does not know
    function automatic logic [7:0] pick_bad_char();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while ((b >= CH_0 && b <= CH_9) || b == CH_SPACE || b == CH_MUL ||
                   b == CH_DIV || b == CH_ADD || b == CH_SUB || b == CH_EQ);
        return b;
    endfunction

    // one expression closed by '=': mostly well formed, some noise and odd cases
    function automatic void build_expr();
        int kind;
        int nterms;
        int nfact;
        bit after_div;
        kind = $urandom_range(99);
        if (kind < 4) begin
            // most negative value divided by minus one (4294967295 wraps to -1)
            put_text("2147483648/4294967295");
        end else if (kind < 12) begin
            // raw noise over the whole byte range
            repeat ($urandom_range(6, 1)) begin
                char_q.push_back(8'($urandom_range(255)));
            end
        end else begin
            nterms = $urandom_range(4, 1);
            for (int t = 0; t < nterms; t++) begin
                if (t != 0) begin
                    put_char($urandom_range(1) ? CH_ADD : CH_SUB);
                end else if ($urandom_range(99) < 25) begin
                    put_char(CH_SUB);
                end
                nfact     = $urandom_range(3, 1);
                after_div = 1'b0;
                for (int f = 0; f < nfact; f++) begin
                    if (f != 0) begin
                        after_div = 1'($urandom_range(1));
                        put_char(after_div ? CH_DIV : CH_MUL);
                    end
                    if (after_div && $urandom_range(99) < 12) begin
                        put_char(CH_0);
                    end else if ($urandom_range(99) >= 5) begin
                        put_number();
                    end
                    if ($urandom_range(99) < 3) begin
                        put_char(pick_bad_char());
                    end
                end
            end
        end
        put_char(CH_EQ);
    endfunction

    // sender side: optional idle gap, then hold valid until the item is taken
    task automatic send_char(input logic [7:0] c);
        while (idle_on && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_queue();
        logic [7:0] c;
        while (char_q.size() > 0) begin
            c = char_q.pop_front();
            send_char(c);
            chars_sent++;
        end
    endtask

    // sender holds off until every expected result has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= 8'h00;
        i_ready     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: leading minus with truncating division, spaces joining digits,
        // divide by zero kept over a later bad character, both byte extremes as
        // bad characters, a missing trailing operand and a leading multiply
        put_text("-7/2=");
        put_text("1 2*3=");
        put_text("9/0+");
        char_q.push_back(8'h00);
        put_text("=");
        char_q.push_back(8'hFF);
        put_text("=");
        put_text("4-=");
        put_text("*5=");
        send_queue();
        drain_results();

        // random expressions, with a quiet stretch where neither side idles
        while (chars_sent < CHAR_TARGET) begin
            idle_on  = !(expr_idx >= 40 && expr_idx < 70);
            stall_on = idle_on;
            build_expr();
            send_queue();
            if ($urandom_range(49) == 0) begin
                drain_results();
            end
            expr_idx++;
        end

        drain_results();
        repeat (50) @(posedge i_clk);

        $display("sent %0d characters in %0d random expressions plus directed cases",
                 chars_sent, expr_idx);
        $display("checked %0d results against the predicted value and status",
                 results_checked);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/iiee_pkg.sv
rtl/core/iiee_mdu.sv
rtl/core/infix_integer_expression_evaluator.sv
dv/iiee_result_checker.sv
dv/infix_integer_expression_evaluator_tb.sv
